### hdl/selective_repeat_send_window_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the selective-repeat send window
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_TOP_ASSERT_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRSW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srsw check failed");
`define SRSW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srsw check failed");
`else
`define SRSW_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SRSW_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/srsw_pkg.sv
// ---------------------------------------------------------------------------
// srsw_pkg
// Types and constants shared by the send window modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package srsw_pkg;

   localparam int DEF_WINDOW_DEPTH  = 32;
   localparam int SLOT_CAP_MAX      = 32;
   localparam logic [5:0]  WINDOW_LIMIT_RST  = 6'd8;
   localparam logic [15:0] TIMEOUT_RST       = 16'd100;

   typedef enum logic [1:0] {
      OP_SEND = 2'd0,
      OP_ACK  = 2'd1,
      OP_TICK = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_SENT    = 3'd0,
      ST_REFUSED = 3'd1,
      ST_DUP_ACK = 3'd2,
      ST_ACKED   = 3'd3,
      ST_ACK_OOR = 3'd4,
      ST_RETX    = 3'd5,
      ST_IDLE    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      PH_OPEN    = 2'd0,
      PH_FULL    = 2'd1,
      PH_CLOSING = 2'd2,
      PH_DONE    = 2'd3
   } phase_type;

   typedef enum logic [0:0] {
      REG_WINDOW_LIMIT  = 1'b0,
      REG_TIMEOUT_TICKS = 1'b1
   } reg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_NORM,
      BK_FREE,
      BK_EMIT,
      BK_T_RD,
      BK_T_CK,
      BK_T_END
   } back_state_type;

   typedef struct packed {
      op_type      operation;
      logic [31:0] ack_number;
      logic        is_eof;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] seq_number;
      logic [4:0]  slot_index;
      logic [31:0] acked_upto;
      logic [5:0]  in_flight;
      phase_type   sender_phase;
      logic        last_of_run;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      op_type      op;
      logic [31:0] ack_seq;
      logic        eof;
   } cmd_type;

   typedef struct packed {
      logic [5:0]  window_limit;
      logic [15:0] timeout_ticks;
   } cfg_type;

endpackage
`default_nettype wire

### hdl/srsw_ram.sv
// ---------------------------------------------------------------------------
// srsw_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module srsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hdl/srsw_front.sv
// ---------------------------------------------------------------------------
// srsw_front
// Accepts requests, classifies them and queues them for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module srsw_front import srsw_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         q_valid,
   output cmd_type      q_item,
   input  wire logic    q_pop
);

   cmd_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       keep;
   cmd_type    cmd;

   always_comb begin
      keep = 1'b1;
      unique case (req_data.operation)
         OP_SEND, OP_ACK, OP_TICK: keep = 1'b1;
         OP_NONE:                  keep = 1'b0;
         default:                  keep = 1'b0;
      endcase
      cmd.op      = req_data.operation;
      cmd.ack_seq = req_data.ack_number - 32'd1;
      cmd.eof     = req_data.is_eof;
   end

   assign req_stall = (count_ff == 2'd2);
   // drop reserved operations at the door
   assign push      = req_valid && !req_stall && keep;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule
`default_nettype wire

### hdl/srsw_back.sv
// ---------------------------------------------------------------------------
// srsw_back
// Window state, ack release, timer scan and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "selective_repeat_send_window_top_assert.svh"
module srsw_back import srsw_pkg::*; #(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    q_valid,
   input  wire cmd_type q_item,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int CAP   = (WINDOW_DEPTH < SLOT_CAP_MAX) ? WINDOW_DEPTH : SLOT_CAP_MAX;
   localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
   localparam logic [5:0] CAP_W = 6'(CAP);

   back_state_type state_ff, state_in;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [5:0]       flight_ff, flight_in;
   logic [31:0]      last_acked_ff, last_acked_in;
   phase_type        phase_ff, phase_in;
   logic [31:0]      tick_ff, tick_in;
   logic [CAP-1:0]   acked_ff, acked_in;
   cmd_type          item_ff, item_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             have_ff, have_in;
   status_type       res_status_ff, res_status_in;
   logic [31:0]      res_seq_ff, res_seq_in;
   logic [IDX_W-1:0] res_slot_ff, res_slot_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic [5:0]       win;
   logic             can_push, push;
   status_type       push_status;
   logic [31:0]      push_seq;
   logic [IDX_W-1:0] push_slot;
   logic             push_last;
   logic             ram_wr, ram_rd;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [31:0]      ram_rd_data;
   logic [31:0]      ack_gap;
   logic [IDX_W-1:0] scan_idx, send_idx, hit_idx;
   logic [5:0]       flight_up;
   logic             expired;

   // ring position of an offset from the oldest slot
   function automatic logic [IDX_W-1:0] ring_at(input logic [IDX_W-1:0] base,
                                                input logic [5:0] off,
                                                input logic [5:0] w);
      logic [6:0] sum;
      sum = 7'(base) + {1'b0, off};
      if (sum >= {1'b0, w}) begin
         sum = sum - {1'b0, w};
      end
      return IDX_W'(sum);
   endfunction

   always_comb begin
      if (cfg.window_limit == 6'd0) begin
         win = 6'd1;
      end else if (cfg.window_limit > CAP_W) begin
         win = CAP_W;
      end else begin
         win = cfg.window_limit;
      end
   end

   srsw_ram #(.WIDTH(32), .DEPTH(CAP)) u_sent_at (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_wr_addr),
      .wr_data (tick_ff),
      .rd_en   (ram_rd),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ack_gap   = item_ff.ack_seq - last_acked_ff;
   assign scan_idx  = ring_at(oldest_ff, cnt_ff, win);
   assign send_idx  = ring_at(oldest_ff, flight_ff, win);
   assign hit_idx   = ring_at(oldest_ff, 6'(ack_gap - 32'd1), win);
   assign flight_up = flight_ff + 6'd1;
   assign expired   = !acked_ff[scan_idx] &&
                      ((tick_ff - ram_rd_data) > {16'd0, cfg.timeout_ticks});
   assign can_push  = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      oldest_in     = oldest_ff;
      flight_in     = flight_ff;
      last_acked_in = last_acked_ff;
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      acked_in      = acked_ff;
      item_in       = item_ff;
      cnt_in        = cnt_ff;
      have_in       = have_ff;
      res_status_in = res_status_ff;
      res_seq_in    = res_seq_ff;
      res_slot_in   = res_slot_ff;
      q_pop         = 1'b0;
      push          = 1'b0;
      push_status   = res_status_ff;
      push_seq      = res_seq_ff;
      push_slot     = res_slot_ff;
      push_last     = 1'b1;
      ram_wr        = 1'b0;
      ram_wr_addr   = scan_idx;
      ram_rd        = 1'b0;
      ram_rd_addr   = scan_idx;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = BK_NORM;
            end
         end
         BK_NORM: begin
            if (flight_ff == 6'd0 && 6'(oldest_ff) >= win) begin
               // fold the pointer back into a shrunk window
               oldest_in = IDX_W'(6'(oldest_ff) - win);
            end else begin
               case (item_ff.op)
                  OP_SEND: begin
                     state_in = BK_EMIT;
                     if (phase_ff != PH_OPEN || flight_ff >= win) begin
                        res_status_in = ST_REFUSED;
                        res_seq_in    = 32'd0;
                        res_slot_in   = '0;
                     end else begin
                        ram_wr             = 1'b1;
                        ram_wr_addr        = send_idx;
                        acked_in[send_idx] = 1'b0;
                        flight_in          = flight_up;
                        if (item_ff.eof) begin
                           phase_in = PH_CLOSING;
                        end else if (flight_up >= win) begin
                           phase_in = PH_FULL;
                        end
                        res_status_in = ST_SENT;
                        res_seq_in    = last_acked_ff + 32'(flight_ff) + 32'd1;
                        res_slot_in   = send_idx;
                     end
                  end
                  OP_ACK: begin
                     res_seq_in  = item_ff.ack_seq;
                     res_slot_in = '0;
                     if (flight_ff == 6'd0 || ack_gap == 32'd0 || ack_gap[31]) begin
                        res_status_in = ST_DUP_ACK;
                        state_in      = BK_EMIT;
                     end else if (ack_gap > 32'(flight_ff)) begin
                        res_status_in = ST_ACK_OOR;
                        state_in      = BK_EMIT;
                     end else begin
                        acked_in[hit_idx] = 1'b1;
                        res_status_in     = ST_ACKED;
                        res_slot_in       = hit_idx;
                        state_in          = BK_FREE;
                     end
                  end
                  default: begin
                     tick_in  = tick_ff + 32'd1;
                     cnt_in   = 6'd0;
                     have_in  = 1'b0;
                     state_in = BK_T_RD;
                  end
               endcase
            end
         end
         BK_FREE: begin
            if (flight_ff != 6'd0 && acked_ff[oldest_ff]) begin
               // release one slot from the oldest end
               acked_in[oldest_ff] = 1'b0;
               oldest_in     = (6'(oldest_ff) + 6'd1 >= win) ? '0 : oldest_ff + IDX_W'(1);
               flight_in     = flight_ff - 6'd1;
               last_acked_in = last_acked_ff + 32'd1;
            end else begin
               if (phase_ff == PH_CLOSING && flight_ff == 6'd0) begin
                  phase_in = PH_DONE;
               end else if (phase_ff != PH_CLOSING && phase_ff != PH_DONE &&
                            flight_ff < win) begin
                  phase_in = PH_OPEN;
               end
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (can_push) begin
               push     = 1'b1;
               state_in = BK_IDLE;
            end
         end
         BK_T_RD: begin
            if (cnt_ff == flight_ff) begin
               state_in = BK_T_END;
            end else begin
               ram_rd   = 1'b1;
               state_in = BK_T_CK;
            end
         end
         BK_T_CK: begin
            if (!expired) begin
               cnt_in   = cnt_ff + 6'd1;
               state_in = BK_T_RD;
            end else if (!have_ff || can_push) begin
               // restart this slot's timer, hold it until the next one shows
               ram_wr        = 1'b1;
               push          = have_ff;
               push_last     = 1'b0;
               have_in       = 1'b1;
               res_status_in = ST_RETX;
               res_seq_in    = last_acked_ff + 32'(cnt_ff) + 32'd1;
               res_slot_in   = scan_idx;
               cnt_in        = cnt_ff + 6'd1;
               state_in      = BK_T_RD;
            end
         end
         BK_T_END: begin
            if (can_push) begin
               push = 1'b1;
               if (!have_ff) begin
                  push_status = ST_IDLE;
                  push_seq    = 32'd0;
                  push_slot   = '0;
               end
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = push ? 1'b1 : (out_valid_ff && rsp_stall);
      out_in       = out_ff;
      if (push) begin
         out_in.status       = push_status;
         out_in.seq_number   = push_seq;
         out_in.slot_index   = 5'(push_slot);
         out_in.acked_upto   = last_acked_ff;
         out_in.in_flight    = flight_ff;
         out_in.sender_phase = phase_ff;
         out_in.last_of_run  = push_last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         oldest_ff     <= '0;
         flight_ff     <= 6'd0;
         last_acked_ff <= 32'd0;
         phase_ff      <= PH_OPEN;
         tick_ff       <= 32'd0;
         acked_ff      <= '0;
         have_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         oldest_ff     <= oldest_in;
         flight_ff     <= flight_in;
         last_acked_ff <= last_acked_in;
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         acked_ff      <= acked_in;
         have_ff       <= have_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_seq_ff    <= res_seq_in;
      res_slot_ff   <= res_slot_in;
      out_ff        <= out_in;
   end

   `SRSW_ASSERT_NOW(a_flight_cap, clock, reset, 1'b1, flight_ff <= CAP_W)
   `SRSW_ASSERT_NEXT(a_tick_only_on_tick, clock, reset, state_ff != BK_NORM, tick_ff == $past(tick_ff))
   `SRSW_ASSERT_NOW(a_push_state, clock, reset, push, state_ff == BK_EMIT || state_ff == BK_T_CK || state_ff == BK_T_END)
   `SRSW_ASSERT_NEXT(a_free_no_grow, clock, reset, state_ff == BK_FREE, flight_ff <= $past(flight_ff))

endmodule
`default_nettype wire

### hdl/selective_repeat_send_window_top.sv
// ---------------------------------------------------------------------------
// selective_repeat_send_window_top
// Sender window of a selective-repeat link: send, ack and tick requests.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one request (send, ack or tick) with valid/stall handshake;
//   rsp_* returns the results, last_of_run set on the final one per request.
//   csr_* is an APB-style port: window_limit at 0x0, timeout_ticks at 0x4.
// Timing:
//   Requests enter a two-deep queue, so req_stall rises only when it is full.
//   A send or a rejected ack passes BK_NORM and then BK_EMIT after leaving
//   the queue; a taken ack passes BK_NORM, then BK_FREE, which releases one
//   slot per step, then BK_EMIT; a tick scans the in-flight slots through the
//   timestamp RAM read port with a read step and a check step per slot, and
//   emits up to one retransmit per checked slot.
//   Reserved operation code 3 is accepted and gives no result.
// Reset:
//   Synchronous; empties the window, phase open, tick counter zero,
//   window_limit 8, timeout_ticks 100. No clearing pass is needed.
// Stall:
//   A stalled result holds in the output register; the back end waits,
//   the queue keeps taking requests until full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module selective_repeat_send_window_top import srsw_pkg::*; #(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type     cfg_ff, cfg_in;
   logic        csr_wr;
   reg_type     csr_reg;
   logic        q_valid, q_pop;
   cmd_type     q_item;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = reg_type'(csr_paddr[2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_reg)
            REG_WINDOW_LIMIT:  cfg_in.window_limit  = csr_pwdata[5:0];
            REG_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
      unique case (csr_reg)
         REG_WINDOW_LIMIT:  csr_prdata = {26'd0, cfg_ff.window_limit};
         REG_TIMEOUT_TICKS: csr_prdata = {16'd0, cfg_ff.timeout_ticks};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_limit  <= WINDOW_LIMIT_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   srsw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   srsw_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
